// ===== rtl/text_console_writer_defines.svh =====
// ---------------------------------------------------------------------------
// text_console_writer_defines.svh
// Assertion macros for the text console writer.
// ---------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// cond must never hold
`define CTW_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

// ante implies cons in the same cycle
`define CTW_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// ante implies cons in the next cycle
`define CTW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define CTW_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`define CTW_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg)
`define CTW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== rtl/ctw_pkg.sv =====
// ---------------------------------------------------------------------------
// ctw_pkg
// Shared constants and controller/datapath interface types.
// ---------------------------------------------------------------------------
package ctw_pkg;

  // character codes with special handling
  localparam logic [7:0] CH_BACKSPACE = 8'd8;
  localparam logic [7:0] CH_NEWLINE   = 8'd10;
  localparam logic [7:0] CH_RETURN    = 8'd13;

  // cell format: attribute above character
  localparam logic [7:0]  CELL_ATTR  = 8'h07;
  localparam logic [15:0] CELL_BLANK = {CELL_ATTR, 8'h20};

  // action codes
  localparam logic ACT_PUT  = 1'b0;
  localparam logic ACT_READ = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture the incoming transaction
    logic decode;    // update cursor, stage cell write or issue read
    logic ptr_init;  // start the scroll sweep
    logic ptr_inc;   // advance the sweep pointer
    logic scan_rd;   // scroll sweep read
    logic clr_wr;    // post-reset clearing write
    logic respond;   // pending write and result capture
  } ctw_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic do_scroll;
    logic scan_last;
    logic clr_last;
  } ctw_stat_t;

endpackage

// ===== rtl/ctw_ctrl.sv =====
// ---------------------------------------------------------------------------
// ctw_ctrl
// Sequencer for the console: clearing pass, decode, scroll sweep, response.
// ---------------------------------------------------------------------------
module ctw_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  ctw_pkg::ctw_stat_t stat,
  output ctw_pkg::ctw_cmd_t  cmd
);
  import ctw_pkg::*;

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_DECODE = 3'd2;
  localparam logic [2:0] S_SCAN   = 3'd3;
  localparam logic [2:0] S_DRAIN  = 3'd4;
  localparam logic [2:0] S_RESP   = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_wr  = 1'b1;
        cmd.ptr_inc = 1'b1;
        if (stat.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.decode = 1'b1;
        if (stat.do_scroll) begin
          cmd.ptr_init = 1'b1;
          state_nxt    = S_SCAN;
        end else begin
          state_nxt = S_RESP;
        end
      end
      S_SCAN: begin
        cmd.scan_rd = 1'b1;
        cmd.ptr_inc = 1'b1;
        if (stat.scan_last) state_nxt = S_DRAIN;
      end
      // last copy write lands here
      S_DRAIN: state_nxt = S_RESP;
      S_RESP: begin
        cmd.respond = 1'b1;
        state_nxt   = S_IDLE;
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

endmodule

// ===== rtl/ctw_datapath.sv =====
// ---------------------------------------------------------------------------
// ctw_datapath
// Screen store, cursor, sweep pointer, copy pipeline and result registers.
// ---------------------------------------------------------------------------
module ctw_datapath #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ctw_pkg::ctw_cmd_t  cmd,
  output ctw_pkg::ctw_stat_t stat,
  input  logic               in_action,
  input  logic [7:0]         in_character,
  input  logic [4:0]         in_read_row,
  input  logic [6:0]         in_read_col,
  output logic               out_valid,
  output logic [15:0]        out_cell_data,
  output logic [4:0]         out_cursor_row,
  output logic [6:0]         out_cursor_col,
  output logic               out_scrolled
);
  import ctw_pkg::*;

  localparam int TOTAL = ROWS * COLUMNS;
  localparam int AW    = $clog2(TOTAL);
  localparam int PW    = $clog2(TOTAL + COLUMNS);
  localparam int RW    = $clog2(ROWS);
  localparam int CW    = $clog2(COLUMNS + 1);

  // captured transaction
  logic             action_r;
  logic [7:0]       char_r;
  logic [4:0]       rrow_r;
  logic [6:0]       rcol_r;

  // cursor
  logic [RW-1:0]    row_r;
  logic [CW-1:0]    col_r;

  // staged cell write and flags
  logic             wr_pend_r;
  logic [AW-1:0]    wr_addr_r;
  logic [15:0]      wr_data_r;
  logic             scr_r;
  logic             in_rng_r;

  // sweep pointer and copy pipeline
  logic [PW-1:0]    ptr_r;
  logic [PW-1:0]    ptr_back;
  logic             cp_vld_r;
  logic [AW-1:0]    cp_waddr_r;
  logic             cp_blank_r;

  // screen store
  logic [15:0]      mem [TOTAL];
  logic [15:0]      mem_q_r;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [15:0]      mem_wdata;
  logic             mem_re;
  logic [AW-1:0]    mem_raddr;

  // result registers
  logic             out_valid_r;
  logic [15:0]      out_cell_r;
  logic [4:0]       out_row_r;
  logic [6:0]       out_col_r;
  logic             out_scr_r;

  // put decode
  logic             is_ret, is_nl, is_bs;
  logic             adv, scroll;
  logic [RW:0]      row_inc;
  logic [RW-1:0]    row1;
  logic [CW-1:0]    col1, col_n, wcol;
  logic             wr_need;
  logic [AW-1:0]    put_addr;
  logic [AW-1:0]    rd_addr;
  logic             rd_in_rng;
  logic [RW+4:0]    row_ext;
  logic [CW+6:0]    col_ext;

  always_comb begin
    is_ret  = (char_r == CH_RETURN);
    is_nl   = (char_r == CH_NEWLINE);
    is_bs   = (char_r == CH_BACKSPACE);
    // wrap or newline moves down one row, maybe scrolling
    adv     = !is_ret && (is_nl || (col_r >= CW'(COLUMNS)));
    row_inc = {1'b0, row_r} + (RW+1)'(1);
    scroll  = adv && (row_inc >= (RW+1)'(ROWS));
    if (!adv)        row1 = row_r;
    else if (scroll) row1 = RW'(ROWS - 1);
    else             row1 = row_inc[RW-1:0];
    col1    = adv ? '0 : col_r;
    // final column and cell write
    wcol    = col1;
    wr_need = 1'b0;
    if (is_ret || is_nl) begin
      col_n = '0;
    end else if (is_bs) begin
      if (col1 != '0) begin
        col_n   = col1 - CW'(1);
        wcol    = col1 - CW'(1);
        wr_need = 1'b1;
      end else begin
        col_n = col1;
      end
    end else begin
      col_n   = col1 + CW'(1);
      wr_need = 1'b1;
    end
  end

  assign put_addr  = AW'(32'(row1) * COLUMNS + 32'(wcol));
  assign rd_addr   = AW'(32'(rrow_r) * COLUMNS + 32'(rcol_r));
  assign rd_in_rng = (32'(rrow_r) < ROWS) && (32'(rcol_r) < COLUMNS);
  assign ptr_back  = ptr_r - PW'(COLUMNS);

  // status to the controller
  assign stat.do_scroll = (action_r == ACT_PUT) && scroll;
  assign stat.scan_last = (ptr_r == PW'(TOTAL + COLUMNS - 1));
  assign stat.clr_last  = (ptr_r == PW'(TOTAL - 1));

  // transaction capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      action_r <= in_action;
      char_r   <= in_character;
      rrow_r   <= in_read_row;
      rcol_r   <= in_read_col;
    end
  end

  // cursor and staged write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r     <= RW'(1);
      col_r     <= '0;
      wr_pend_r <= 1'b0;
    end else if (cmd.decode) begin
      if (action_r == ACT_PUT) begin
        row_r     <= row1;
        col_r     <= col_n;
        wr_pend_r <= wr_need;
      end else begin
        wr_pend_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.decode) begin
      wr_addr_r <= put_addr;
      wr_data_r <= is_bs ? CELL_BLANK : {CELL_ATTR, char_r};
      scr_r     <= (action_r == ACT_PUT) && scroll;
      in_rng_r  <= rd_in_rng;
    end
  end

  // sweep pointer: clearing pass from 0, scroll from row 2
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r <= '0;
    end else if (cmd.ptr_init) begin
      ptr_r <= PW'(2 * COLUMNS);
    end else if (cmd.ptr_inc) begin
      ptr_r <= ptr_r + PW'(1);
    end
  end

  // copy pipeline: read row r+1, write row r in the cycle after;
  // reads past the end feed blanks into the bottom row
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cp_vld_r <= 1'b0;
    end else begin
      cp_vld_r <= cmd.scan_rd;
    end
  end

  always_ff @(posedge clk) begin
    cp_waddr_r <= ptr_back[AW-1:0];
    cp_blank_r <= (ptr_r >= PW'(TOTAL));
  end

  // write port select
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = ptr_r[AW-1:0];
    mem_wdata = CELL_BLANK;
    if (cmd.clr_wr) begin
      mem_we = 1'b1;
    end else if (cp_vld_r) begin
      mem_we    = 1'b1;
      mem_waddr = cp_waddr_r;
      mem_wdata = cp_blank_r ? CELL_BLANK : mem_q_r;
    end else if (cmd.respond && wr_pend_r) begin
      mem_we    = 1'b1;
      mem_waddr = wr_addr_r;
      mem_wdata = wr_data_r;
    end
  end

  // read port select
  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = ptr_r[AW-1:0];
    if (cmd.scan_rd && (ptr_r < PW'(TOTAL))) begin
      mem_re = 1'b1;
    end else if (cmd.decode && (action_r == ACT_READ) && rd_in_rng) begin
      mem_re    = 1'b1;
      mem_raddr = rd_addr;
    end
  end

  // screen store
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
  end

  always_ff @(posedge clk) begin
    if (mem_re) mem_q_r <= mem[mem_raddr];
  end

  // result registers
  assign row_ext = {{5{1'b0}}, row_r};
  assign col_ext = {{7{1'b0}}, col_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.respond;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.respond) begin
      out_cell_r <= ((action_r == ACT_READ) && in_rng_r) ? mem_q_r : 16'h0000;
      out_row_r  <= row_ext[4:0];
      out_col_r  <= col_ext[6:0];
      out_scr_r  <= scr_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_cell_data  = out_cell_r;
  assign out_cursor_row = out_row_r;
  assign out_cursor_col = out_col_r;
  assign out_scrolled   = out_scr_r;

endmodule

// ===== rtl/text_console_writer.sv =====
// ---------------------------------------------------------------------------
// text_console_writer
// Text-mode console: character writer with cursor, wrap and scroll.
// ---------------------------------------------------------------------------
// Usage:
//   Raise start with in_action/in_character/in_read_row/in_read_col; the
//   transaction is taken at a rising edge where start is high and busy low.
//   A put (in_action 0) prints one byte, handling return, newline and
//   backspace; a read (in_action 1) returns one screen cell.
//   Each transaction yields one result, shown for a single cycle with
//   out_valid high; the receiver cannot stall it.
// Sequencing:
//   Without scrolling a transaction passes through capture, decode and
//   respond, and out_valid is registered from the respond step; a new
//   transaction may be accepted while that result is shown.
//   A scrolling put sweeps rows 2..ROWS-1 plus the blank bottom row through
//   the single-read/single-write screen store, one cell a cycle, then
//   drains the last copy write and responds.
// Reset:
//   Cursor goes to row 1, column 0. A clearing pass then writes a blank
//   cell per cycle over all ROWS*COLUMNS cells, with busy high.
// ---------------------------------------------------------------------------
`include "text_console_writer_defines.svh"

module text_console_writer #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_action,
  input  logic [7:0]  in_character,
  input  logic [4:0]  in_read_row,
  input  logic [6:0]  in_read_col,
  output logic        out_valid,
  output logic [15:0] out_cell_data,
  output logic [4:0]  out_cursor_row,
  output logic [6:0]  out_cursor_col,
  output logic        out_scrolled
);
  import ctw_pkg::*;

  ctw_cmd_t  cmd;
  ctw_stat_t stat;

  // sequencer
  ctw_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  // screen store and cursor
  ctw_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_action      (in_action),
    .in_character   (in_character),
    .in_read_row    (in_read_row),
    .in_read_col    (in_read_col),
    .out_valid      (out_valid),
    .out_cell_data  (out_cell_data),
    .out_cursor_row (out_cursor_row),
    .out_cursor_col (out_cursor_col),
    .out_scrolled   (out_scrolled)
  );

  // checks
  `CTW_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, start && !busy, busy, "not busy after accept")
  `CTW_ASSERT_NEXT(a_single_strobe, clk, rst_n, out_valid, !out_valid, "result strobe held")
  `CTW_ASSERT_IMPLIES(a_result_from_work, clk, rst_n, out_valid, $past(busy), "result without work")
  `CTW_ASSERT_NEVER(a_scroll_no_data, clk, rst_n, out_valid && out_scrolled && (out_cell_data != 16'h0000), "scroll with cell data")

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console writer testbench
// Drives put and read transactions into the console engine and checks every
// result against an in-bench model of the screen store and cursor. The run
// covers cursor wrap, scrolling, backspace, return and newline handling, and
// out-of-range reads, with random idle bursts on the command side.
// ----------------------------------------------------------------------------
module testbench;
  import ctw_pkg::*;

  localparam int COLS           = 80;
  localparam int ROWS           = 25;
  localparam int ITEM_TARGET    = 900;
  localparam int QUIET_TAIL     = 60;
  localparam int WATCHDOG_LIMIT = 12000;
  localparam int SETTLE_CYCLES  = 8;

  // one command transaction
  typedef struct packed {
    logic       action;
    logic [7:0] character;
    logic [4:0] read_row;
    logic [6:0] read_col;
    logic       drain;    // hold off until every result is back
  } console_op_t;

  // one result transaction
  typedef struct packed {
    logic [15:0] cell_val;
    logic [4:0]  row;
    logic [6:0]  col;
    logic        scrolled;
  } console_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        in_action = ACT_PUT;
  logic [7:0]  in_character = '0;
  logic [4:0]  in_read_row = '0;
  logic [6:0]  in_read_col = '0;
  logic        out_valid;
  logic [15:0] out_cell_data;
  logic [4:0]  out_cursor_row;
  logic [6:0]  out_cursor_col;
  logic        out_scrolled;

  console_op_t     pending_ops[$];
  console_result_t predicted_q[$];
  console_op_t     cur_op;

  // model of the screen and cursor
  logic [15:0] screen_image [0:ROWS*COLS-1];
  int          cur_row;
  int          cur_col;

  // bookkeeping
  int err_cnt      = 0;
  int sent_cnt     = 0;
  int put_cnt      = 0;
  int read_cnt     = 0;
  int oob_read_cnt = 0;
  int wrap_cnt     = 0;
  int scroll_cnt   = 0;
  int gap_left     = 0;
  int stall_cycles = 0;
  bit idle_phase   = 1'b1;

  always #2 clk = ~clk;

  text_console_writer #(
    .COLUMNS (COLS),
    .ROWS    (ROWS)
  ) i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_action      (in_action),
    .in_character   (in_character),
    .in_read_row    (in_read_row),
    .in_read_col    (in_read_col),
    .out_valid      (out_valid),
    .out_cell_data  (out_cell_data),
    .out_cursor_row (out_cursor_row),
    .out_cursor_col (out_cursor_col),
    .out_scrolled   (out_scrolled)
  );

  // apply one transaction to the screen model and return what it should report
  function automatic console_result_t apply_console_op(console_op_t op);
    console_result_t res;
    bit              new_line;
    int              r;
    int              c;
    res = '0;
    if (op.action == ACT_READ) begin
      read_cnt++;
      if (op.read_row < ROWS && op.read_col < COLS)
        res.cell_val = screen_image[op.read_row * COLS + op.read_col];
      else
        oob_read_cnt++;
    end else begin
      put_cnt++;
      if (op.character == CH_RETURN) begin
        cur_col = 0;
      end else begin
        if (cur_col >= COLS) wrap_cnt++;
        new_line = (op.character == CH_NEWLINE) || (cur_col >= COLS);
        if (new_line) begin
          cur_col = 0;
          cur_row++;
          // bottom overflow: shift rows 2..last up, status row untouched
          if (cur_row >= ROWS) begin
            for (r = 1; r < ROWS - 1; r++)
              for (c = 0; c < COLS; c++)
                screen_image[r*COLS + c] = screen_image[(r+1)*COLS + c];
            for (c = 0; c < COLS; c++)
              screen_image[(ROWS-1)*COLS + c] = CELL_BLANK;
            cur_row      = ROWS - 1;
            res.scrolled = 1'b1;
          end
        end
        if (op.character == CH_BACKSPACE) begin
          if (cur_col > 0) begin
            cur_col--;
            screen_image[cur_row*COLS + cur_col] = CELL_BLANK;
          end
        end else if (op.character != CH_NEWLINE) begin
          screen_image[cur_row*COLS + cur_col] = {CELL_ATTR, op.character};
          cur_col++;
        end
      end
    end
    res.row = 5'(cur_row);
    res.col = 7'(cur_col);
    return res;
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    err_cnt++;
  endtask

  task automatic queue_put(input logic [7:0] ch);
    console_op_t op;
    op.action    = ACT_PUT;
    op.character = ch;
    op.read_row  = 5'($urandom_range(0, 31));
    op.read_col  = 7'($urandom_range(0, 127));
    op.drain     = 1'b0;
    pending_ops.push_back(op);
  endtask

  task automatic queue_read(input int row, input int col);
    console_op_t op;
    op.action    = ACT_READ;
    op.character = 8'($urandom_range(0, 255));
    op.read_row  = 5'(row);
    op.read_col  = 7'(col);
    op.drain     = 1'b0;
    pending_ops.push_back(op);
  endtask

  function automatic logic [7:0] text_char();
    if ($urandom_range(0, 3) == 0) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(32, 126));
  endfunction

  // return, a full line of text, then one byte that meets the pending wrap
  task automatic queue_full_line(input logic [7:0] tail);
    queue_put(CH_RETURN);
    repeat (COLS) queue_put(8'($urandom_range(32, 126)));
    queue_put(tail);
  endtask

  // driver: present the next transaction, hold it until accepted
  always @(posedge clk) begin : drive_proc
    console_op_t nxt;
    logic        take;
    logic        start_next;
    if (!rst_n) begin
      start    <= 1'b0;
      gap_left  = 0;
    end else begin
      take       = start && !busy;
      start_next = start && !take;
      if (take) begin
        predicted_q.push_back(apply_console_op(cur_op));
        sent_cnt++;
        if (sent_cnt % 40 == 0) idle_phase = ($urandom_range(0, 2) != 0);
        if (idle_phase && pending_ops.size() > QUIET_TAIL && $urandom_range(0, 3) == 0)
          gap_left = $urandom_range(1, 6);
      end
      if (!start_next) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_ops.size() > 0 &&
                     !(pending_ops[0].drain && predicted_q.size() > 0)) begin
          nxt           = pending_ops.pop_front();
          cur_op        = nxt;
          in_action    <= nxt.action;
          in_character <= nxt.character;
          in_read_row  <= nxt.read_row;
          in_read_col  <= nxt.read_col;
          start_next    = 1'b1;
        end
      end
      start <= start_next;
    end
  end

  // monitor: compare each result with the oldest prediction
  always @(posedge clk) begin : check_proc
    console_result_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (out_scrolled === 1'b1) scroll_cnt++;
      if (predicted_q.size() == 0) begin
        flag_mismatch("result with no transaction outstanding");
      end else begin
        want = predicted_q.pop_front();
        if (out_cell_data !== want.cell_val)
          flag_mismatch($sformatf("cell_data got %h want %h", out_cell_data, want.cell_val));
        if (out_cursor_row !== want.row)
          flag_mismatch($sformatf("cursor_row got %0d want %0d", out_cursor_row, want.row));
        if (out_cursor_col !== want.col)
          flag_mismatch($sformatf("cursor_col got %0d want %0d", out_cursor_col, want.col));
        if (out_scrolled !== want.scrolled)
          flag_mismatch($sformatf("scrolled got %b want %b", out_scrolled, want.scrolled));
      end
    end
  end

  // watchdog: cycles without any accepted transaction on either side
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid === 1'b1)
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int i;
    int kind;
    int len;
    int drain_idx;

    // model reset state
    for (i = 0; i < ROWS*COLS; i++) screen_image[i] = CELL_BLANK;
    cur_row = 1;
    cur_col = 0;

    // directed: reads at two opposite corners and out of range
    queue_read(0, 0);
    queue_read(ROWS-1, COLS-1);
    queue_read(ROWS, 0);
    queue_read(0, COLS);
    queue_read(31, 127);
    // backspace at column 0 does nothing
    queue_put(CH_BACKSPACE);
    queue_put(8'h00);
    queue_put(8'hFF);
    queue_put("A");
    queue_put(CH_BACKSPACE);
    queue_read(1, 2);
    queue_read(1, 1);
    queue_read(1, 0);
    queue_put(CH_RETURN);
    queue_put(CH_NEWLINE);
    queue_put("z");
    queue_read(2, 0);

    // wrap pending met by each kind of byte; first waits for an empty pipe
    drain_idx = pending_ops.size();
    queue_full_line(CH_BACKSPACE);
    pending_ops[drain_idx].drain = 1'b1;
    queue_full_line(CH_RETURN);
    queue_full_line(CH_NEWLINE);
    queue_full_line(8'($urandom_range(32, 126)));

    // random: mostly text with line control, some reads
    while (pending_ops.size() < ITEM_TARGET) begin
      kind = $urandom_range(0, 99);
      if (kind < 36) begin
        len = $urandom_range(1, 24);
        repeat (len) queue_put(text_char());
      end else if (kind < 52) begin
        len = $urandom_range(1, 3);
        repeat (len) queue_put(CH_NEWLINE);
      end else if (kind < 60) begin
        len = $urandom_range(1, 4);
        repeat (len) queue_put(CH_BACKSPACE);
      end else if (kind < 65) begin
        queue_put(CH_RETURN);
      end else if (kind < 68) begin
        case ($urandom_range(0, 3))
          0:       queue_full_line(CH_BACKSPACE);
          1:       queue_full_line(CH_RETURN);
          2:       queue_full_line(CH_NEWLINE);
          default: queue_full_line(text_char());
        endcase
      end else begin
        len = $urandom_range(1, 4);
        repeat (len) begin
          if ($urandom_range(0, 9) < 7)
            queue_read($urandom_range(0, ROWS-1), $urandom_range(0, COLS-1));
          else
            queue_read($urandom_range(0, 31), $urandom_range(0, 127));
        end
      end
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // wait for all stimulus to drain, then let the pipe settle
    do @(posedge clk);
    while (pending_ops.size() != 0 || start || predicted_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d transactions: %0d puts, %0d reads (%0d out of range)",
             sent_cnt, put_cnt, read_cnt, oob_read_cnt);
    $display("Saw %0d scrolls and %0d puts landing on a pending wrap", scroll_cnt, wrap_cnt);
    if (err_cnt == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
